// ===== rtl/lss_pkg.sv =====
`default_nettype none

package lss_pkg;

	// default and largest useful system size
	localparam int MAX_UNKNOWNS_DEF = 8;

	// signed Q16.16 values
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;

	// configuration register map
	localparam logic [3:0] SIZE_RESET   = 4'd4;
	localparam int         REG_SYS_SIZE = 0;

	// load item kinds
	localparam logic KIND_COEF = 1'b0;
	localparam logic KIND_RHS  = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic [2:0]              row_index;
		logic [2:0]              column_index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} load_t;

	typedef struct packed {
		logic [2:0]              unknown_index;
		logic signed [VAL_W-1:0] solution;
		logic                    singular;
		logic                    final_result;
	} result_t;

	// divider result handed back to the sequencer
	typedef struct packed {
		logic                    zero_div;
		logic signed [VAL_W-1:0] quot;
	} div_res_t;

endpackage

`default_nettype wire

// ===== rtl/lss_ram.sv =====
`default_nettype none

module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lss_div.sv =====
`default_nettype none

module lss_div
	import lss_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [VAL_W-1:0] dividend,
	input  wire logic signed [VAL_W-1:0] divisor,
	output logic                         done,
	output div_res_t                     res
);

	localparam int NUM_W = VAL_W + FRAC_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic              busy_q, fin_q, done_q, zero_q, neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q, quo_q;
	logic [VAL_W-1:0]  den_q, rem_q;
	div_res_t          res_q;

	logic [VAL_W-1:0]  a_mag, b_mag;
	logic [VAL_W:0]    trial;
	logic [VAL_W:0]    shifted;
	logic [VAL_W-1:0]  quot_sat;

	assign a_mag   = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
	assign b_mag   = divisor[VAL_W-1] ? VAL_W'(-divisor) : VAL_W'(divisor);
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// apply sign and saturate the magnitude quotient
	always_comb begin
		if (neg_q) begin
			if (quo_q > NUM_W'({1'b1, {(VAL_W-1){1'b0}}})) begin
				quot_sat = {1'b1, {(VAL_W-1){1'b0}}};
			end else begin
				quot_sat = VAL_W'(-quo_q);
			end
		end else begin
			if (quo_q > NUM_W'({1'b0, {(VAL_W-1){1'b1}}})) begin
				quot_sat = {1'b0, {(VAL_W-1){1'b1}}};
			end else begin
				quot_sat = quo_q[VAL_W-1:0];
			end
		end
	end

	// control: one quotient bit per cycle, then fin_q and done_q are set in turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (divisor == '0) begin
					fin_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (int'(cnt_q) == NUM_W - 1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// restoring division datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {a_mag, {FRAC_W{1'b0}}};
			den_q  <= b_mag;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!trial[VAL_W]) begin
				rem_q <= trial[VAL_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VAL_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
		if (fin_q) begin
			res_q.zero_div <= zero_q;
			res_q.quot     <= zero_q ? '0 : quot_sat;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== rtl/linear_system_solver_top.sv =====
// Solves A x = b by Gaussian elimination with column pivoting in signed
// Q16.16. Load items are taken one per cycle while the block is idle; the
// item marked last starts the solve and load_ready stays low until all
// results have been taken. The solve first copies the coefficient store
// into a working RAM, then runs every step on one shared multiply/subtract
// path and one bit-serial divider: each element update passes through
// read, multiply, scale and subtract states, each pivot candidate through
// read and compare states. The solve time is dominated by the divider.
// Column swaps only exchange entries of the unknown permutation, no data
// moves. Results come out one per unknown in original unknown order,
// singular set when any divisor was zero.
`default_nettype none

module linear_system_solver_top
	import lss_pkg::*;
#(
	parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load_valid,
	output logic             load_ready,
	input  wire load_t       load,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
	localparam int CW    = $clog2(MAX_UNKNOWNS + 1);
	localparam int DEPTH = MAX_UNKNOWNS * MAX_UNKNOWNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_COPY    = 17'h00002,
		S_PIV_RD  = 17'h00004,
		S_PIV_CMP = 17'h00008,
		S_SWAP1   = 17'h00010,
		S_SWAP2   = 17'h00020,
		S_PVT_RD  = 17'h00040,
		S_PVT_WT  = 17'h00080,
		S_ROW_RD  = 17'h00100,
		S_DIV_GO  = 17'h00200,
		S_DIV_WT  = 17'h00400,
		S_MUL1    = 17'h00800,
		S_MUL2    = 17'h01000,
		S_SUB     = 17'h02000,
		S_ELM_RD  = 17'h04000,
		S_SOL_GO  = 17'h08000,
		S_SOL_WT  = 17'h10000
	} state_t;

	// output state kept apart from the enum: OUT is its own flag
	state_t            state_q;
	logic              out_q;

	logic [3:0]        sys_size_q;
	logic [CW-1:0]     n_q, i_q, k_q, j_q, u_q;
	logic [AW:0]       cp_q;
	logic [IW-1:0]     best_q, tmp_q;
	logic [VAL_W:0]    best_mag_q;
	logic              back_q, tgt_a_q, singular_q;
	logic [IW-1:0]     perm_q [MAX_UNKNOWNS];

	logic signed [VAL_W-1:0] rhs_q [MAX_UNKNOWNS];
	logic signed [VAL_W-1:0] b_q   [MAX_UNKNOWNS];
	logic signed [VAL_W-1:0] sol_q [MAX_UNKNOWNS];
	logic signed [VAL_W-1:0] piv_q, bi_q, r_q;
	logic signed [63:0]      prod_s1;
	logic signed [VAL_W-1:0] mres_s2;

	logic              load_acc, cfg_wr;
	logic [CW-1:0]     n_eff;

	logic              mat_we, mat_re;
	logic [AW-1:0]     mat_waddr, mat_raddr;
	logic [VAL_W-1:0]  mat_rdata;

	logic              w_we, w_re;
	logic [AW-1:0]     w_waddr, w_raddr;
	logic [VAL_W-1:0]  w_wdata, w_rdata;

	logic [IW-1:0]     pidx, bidx;
	logic [IW-1:0]     perm_rd;
	logic signed [VAL_W-1:0] b_rd;

	logic              div_start, div_done;
	logic signed [VAL_W-1:0] div_num;
	div_res_t          div_res;

	logic [VAL_W:0]          cand_mag;
	logic signed [63:0]      prod_adj;
	logic signed [47:0]      prod_shr;
	logic signed [VAL_W-1:0] mres_next;
	logic signed [VAL_W-1:0] sub_x;
	logic signed [VAL_W:0]   diff;
	logic signed [VAL_W-1:0] sub_res;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
	                                             input logic [IW-1:0] c);
		return AW'(int'(r) * MAX_UNKNOWNS + int'(c));
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (int'(paddr[2]) == REG_SYS_SIZE)
	                && (paddr[1:0] == 2'b00);
	assign prdata = (int'(paddr[2]) == REG_SYS_SIZE) ? {28'd0, sys_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_size_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			sys_size_q <= pwdata[3:0];
		end
	end

	// effective size: zero counts as one, large values clip
	always_comb begin
		if (sys_size_q == 4'd0) begin
			n_eff = CW'(1);
		end else if (int'(sys_size_q) > MAX_UNKNOWNS) begin
			n_eff = CW'(MAX_UNKNOWNS);
		end else begin
			n_eff = CW'(sys_size_q);
		end
	end

	assign load_ready = (state_q == S_IDLE) && !out_q;
	assign load_acc   = load_valid && load_ready;

	// loaded coefficient store
	assign mat_we    = load_acc && (load.kind == KIND_COEF)
	                   && (int'(load.row_index) < MAX_UNKNOWNS)
	                   && (int'(load.column_index) < MAX_UNKNOWNS);
	assign mat_waddr = AW'(int'(load.row_index) * MAX_UNKNOWNS + int'(load.column_index));
	assign mat_re    = (state_q == S_COPY) && (int'(cp_q) < DEPTH);
	assign mat_raddr = cp_q[AW-1:0];

	lss_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (load.value),
		.re    (mat_re),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	// read selects for permutation and right-hand side
	always_comb begin
		case (state_q)
			S_SWAP1: pidx = best_q;
			S_ELM_RD: pidx = j_q[IW-1:0];
			S_MUL1, S_MUL2, S_SUB: pidx = tgt_a_q ? j_q[IW-1:0] : i_q[IW-1:0];
			default: pidx = i_q[IW-1:0];
		endcase
	end
	assign perm_rd = perm_q[pidx];
	assign bidx    = (state_q == S_PVT_RD) ? i_q[IW-1:0] : k_q[IW-1:0];
	assign b_rd    = b_q[bidx];

	// working matrix reads and writes
	always_comb begin
		w_re    = 1'b0;
		w_raddr = '0;
		case (state_q)
			S_PIV_RD: begin
				w_re    = 1'b1;
				w_raddr = cell_addr(i_q, perm_q[k_q[IW-1:0]]);
			end
			S_PVT_RD: begin
				w_re    = 1'b1;
				w_raddr = cell_addr(i_q, perm_rd);
			end
			S_ROW_RD: begin
				w_re    = 1'b1;
				w_raddr = cell_addr(k_q, perm_rd);
			end
			S_ELM_RD: begin
				w_re    = 1'b1;
				w_raddr = cell_addr(i_q, perm_rd);
			end
			S_MUL1: begin
				w_re    = tgt_a_q;
				w_raddr = cell_addr(k_q, perm_rd);
			end
			default: begin
				w_re    = 1'b0;
				w_raddr = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_COPY) begin
			w_we    = (cp_q != '0);
			w_waddr = AW'(cp_q - 1'b1);
			w_wdata = mat_rdata;
		end else begin
			w_we    = (state_q == S_SUB) && tgt_a_q;
			w_waddr = cell_addr(k_q, perm_rd);
			w_wdata = sub_res;
		end
	end

	lss_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_work_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// shared divider
	assign div_start = (state_q == S_DIV_GO) || (state_q == S_SOL_GO);
	assign div_num   = (state_q == S_SOL_GO) ? bi_q : w_rdata;

	lss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (piv_q),
		.done     (div_done),
		.res      (div_res)
	);

	// pivot candidate magnitude, exact at 33 bits
	assign cand_mag = w_rdata[VAL_W-1] ? (33'd0 - {1'b1, w_rdata}) : {1'b0, w_rdata};

	// product scaled down with truncation toward zero, then saturated
	assign prod_adj = prod_s1 + (prod_s1[63] ? 64'sd65535 : 64'sd0);
	assign prod_shr = prod_adj[63:16];
	always_comb begin
		if ((&prod_shr[47:31]) || !(|prod_shr[47:31])) begin
			mres_next = prod_shr[31:0];
		end else if (prod_shr[47]) begin
			mres_next = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			mres_next = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// saturating subtract
	assign sub_x = tgt_a_q ? w_rdata : b_rd;
	assign diff  = {sub_x[VAL_W-1], sub_x} - {mres_s2[VAL_W-1], mres_s2};
	always_comb begin
		if (diff[VAL_W] == diff[VAL_W-1]) begin
			sub_res = diff[VAL_W-1:0];
		end else if (diff[VAL_W]) begin
			sub_res = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sub_res = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_q      <= 1'b0;
			n_q        <= '0;
			i_q        <= '0;
			k_q        <= '0;
			j_q        <= '0;
			u_q        <= '0;
			cp_q       <= '0;
			best_q     <= '0;
			tmp_q      <= '0;
			best_mag_q <= '0;
			back_q     <= 1'b0;
			tgt_a_q    <= 1'b0;
			singular_q <= 1'b0;
			for (int p = 0; p < MAX_UNKNOWNS; p++) begin
				perm_q[p] <= IW'(p);
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_q) begin
						if (result_ready) begin
							if (int'(u_q) + 1 == int'(n_q)) begin
								out_q <= 1'b0;
							end else begin
								u_q <= u_q + 1'b1;
							end
						end
					end else if (load_acc && load.last) begin
						n_q        <= n_eff;
						cp_q       <= '0;
						singular_q <= 1'b0;
						for (int p = 0; p < MAX_UNKNOWNS; p++) begin
							perm_q[p] <= IW'(p);
						end
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					cp_q <= cp_q + 1'b1;
					if (int'(cp_q) == DEPTH) begin
						i_q <= '0;
						k_q <= '0;
						if (n_q == CW'(1)) begin
							back_q  <= 1'b1;
							state_q <= S_PVT_RD;
						end else begin
							back_q  <= 1'b0;
							state_q <= S_PIV_RD;
						end
					end
				end
				S_PIV_RD: begin
					state_q <= S_PIV_CMP;
				end
				S_PIV_CMP: begin
					if ((k_q == i_q) || (cand_mag > best_mag_q)) begin
						best_mag_q <= cand_mag;
						best_q     <= k_q[IW-1:0];
					end
					if (int'(k_q) + 1 == int'(n_q)) begin
						state_q <= S_SWAP1;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_PIV_RD;
					end
				end
				// no swap when the pivot is already in place
				S_SWAP1: begin
					if (best_q == i_q[IW-1:0]) begin
						state_q <= S_PVT_RD;
					end else begin
						tmp_q   <= perm_rd;
						state_q <= S_SWAP2;
					end
				end
				S_SWAP2: begin
					perm_q[best_q]        <= perm_rd;
					perm_q[i_q[IW-1:0]]   <= tmp_q;
					state_q               <= S_PVT_RD;
				end
				S_PVT_RD: begin
					state_q <= S_PVT_WT;
				end
				S_PVT_WT: begin
					if (back_q) begin
						if (i_q == '0) begin
							state_q <= S_SOL_GO;
						end else begin
							k_q     <= i_q - 1'b1;
							state_q <= S_ROW_RD;
						end
					end else begin
						k_q     <= i_q + 1'b1;
						state_q <= S_ROW_RD;
					end
				end
				S_ROW_RD: begin
					state_q <= S_DIV_GO;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WT;
				end
				S_DIV_WT: begin
					if (div_done) begin
						singular_q <= singular_q | div_res.zero_div;
						tgt_a_q    <= 1'b0;
						state_q    <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (tgt_a_q) begin
						if (int'(j_q) + 1 < int'(n_q)) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_ELM_RD;
						end else if (int'(k_q) + 1 < int'(n_q)) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ROW_RD;
						end else if (int'(i_q) + 2 < int'(n_q)) begin
							i_q     <= i_q + 1'b1;
							k_q     <= i_q + 1'b1;
							state_q <= S_PIV_RD;
						end else begin
							back_q  <= 1'b1;
							i_q     <= n_q - 1'b1;
							state_q <= S_PVT_RD;
						end
					end else if (back_q) begin
						if (k_q == '0) begin
							state_q <= S_SOL_GO;
						end else begin
							k_q     <= k_q - 1'b1;
							state_q <= S_ROW_RD;
						end
					end else begin
						j_q     <= i_q + 1'b1;
						tgt_a_q <= 1'b1;
						state_q <= S_ELM_RD;
					end
				end
				S_ELM_RD: begin
					state_q <= S_MUL1;
				end
				S_SOL_GO: begin
					state_q <= S_SOL_WT;
				end
				S_SOL_WT: begin
					if (div_done) begin
						singular_q <= singular_q | div_res.zero_div;
						if (i_q == '0) begin
							u_q     <= '0;
							out_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_PVT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// data registers of the solve
	always_ff @(posedge clk) begin
		// right-hand-side load
		if (load_acc && (load.kind == KIND_RHS)) begin
			for (int r = 0; r < MAX_UNKNOWNS; r++) begin
				if (int'(load.row_index) == r) begin
					rhs_q[r] <= load.value;
				end
			end
		end
		// working right-hand side taken at the start of the copy
		if ((state_q == S_COPY) && (cp_q == '0)) begin
			for (int r = 0; r < MAX_UNKNOWNS; r++) begin
				b_q[r] <= rhs_q[r];
			end
		end
		if (state_q == S_PVT_RD) begin
			bi_q <= b_rd;
		end
		if (state_q == S_PVT_WT) begin
			piv_q <= w_rdata;
		end
		if ((state_q == S_DIV_WT) && div_done) begin
			r_q <= div_res.quot;
		end
		// multiply then scale
		if (state_q == S_MUL1) begin
			prod_s1 <= (tgt_a_q ? $signed(w_rdata) : bi_q) * r_q;
		end
		if (state_q == S_MUL2) begin
			mres_s2 <= mres_next;
		end
		if ((state_q == S_SUB) && !tgt_a_q) begin
			for (int r = 0; r < MAX_UNKNOWNS; r++) begin
				if (int'(k_q) == r) begin
					b_q[r] <= sub_res;
				end
			end
		end
		if ((state_q == S_SOL_WT) && div_done) begin
			sol_q[perm_rd] <= div_res.quot;
		end
	end

	// result item
	assign result_valid          = out_q;
	assign result.unknown_index  = 3'(u_q);
	assign result.solution       = sol_q[u_q[IW-1:0]];
	assign result.singular       = singular_q;
	assign result.final_result   = (int'(u_q) + 1 == int'(n_q));

endmodule

`default_nettype wire

// ===== tb/linear_system_solver_top_tb.sv =====
`default_nettype none

module linear_system_solver_top_tb;
	import lss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NMAX = 8;
	localparam int STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic load_valid = 1'b0;
	logic load_ready;
	load_t load = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	linear_system_solver_top DUT (
		.clk(clk), .arst_n(arst_n),
		.load_valid(load_valid), .load_ready(load_ready), .load(load),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [31:0] coef_mem [NMAX*NMAX];
	logic signed [31:0] rhs_mem [NMAX];
	logic [3:0] size_reg = SIZE_RESET;
	bit zero_div_seen;

	load_t pending_loads[$];
	result_t expected_solutions[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
			logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p / 65536);
	endfunction

	function automatic logic signed [31:0] fx_div(logic signed [31:0] a,
			logic signed [31:0] b);
		if (b == 0) begin
			zero_div_seen = 1'b1;
			return '0;
		end
		return clamp32((longint'(a) * 65536) / longint'(b));
	endfunction

	function automatic longint fx_abs(logic signed [31:0] v);
		longint w;
		w = v;
		return (w < 0) ? -w : w;
	endfunction

	// gaussian elimination with column pivoting, pushes one result per unknown
	task automatic predict_solution();
		logic signed [31:0] a [NMAX*NMAX];
		logic signed [31:0] b [NMAX];
		logic signed [31:0] x [NMAX];
		logic signed [31:0] r, t;
		logic [2:0] perm [NMAX];
		logic [2:0] t3;
		int n, best;
		longint best_mag;
		result_t res;
		a = coef_mem;
		b = rhs_mem;
		for (int q = 0; q < NMAX; q++) perm[q] = 3'(q);
		zero_div_seen = 1'b0;
		n = (size_reg == 0) ? 1 : (size_reg > NMAX) ? NMAX : size_reg;
		for (int i = 0; i + 1 < n; i++) begin
			best = i;
			best_mag = fx_abs(a[i*NMAX+i]);
			for (int k = i + 1; k < n; k++) begin
				if (fx_abs(a[i*NMAX+k]) > best_mag) begin
					best_mag = fx_abs(a[i*NMAX+k]);
					best = k;
				end
			end
			if (best != i) begin
				for (int j = 0; j < n; j++) begin
					t = a[j*NMAX+i];
					a[j*NMAX+i] = a[j*NMAX+best];
					a[j*NMAX+best] = t;
				end
				t3 = perm[i];
				perm[i] = perm[best];
				perm[best] = t3;
			end
			for (int k = i + 1; k < n; k++) begin
				r = fx_div(a[k*NMAX+i], a[i*NMAX+i]);
				b[k] = clamp32(longint'(b[k]) - longint'(fx_mul(b[i], r)));
				for (int j = i + 1; j < n; j++)
					a[k*NMAX+j] = clamp32(longint'(a[k*NMAX+j])
						- longint'(fx_mul(a[i*NMAX+j], r)));
			end
		end
		for (int i = n - 1; i >= 1; i--) begin
			for (int k = i - 1; k >= 0; k--) begin
				r = fx_div(a[k*NMAX+i], a[i*NMAX+i]);
				b[k] = clamp32(longint'(b[k]) - longint'(fx_mul(b[i], r)));
			end
			x[perm[i]] = fx_div(b[i], a[i*NMAX+i]);
		end
		x[perm[0]] = fx_div(b[0], a[0]);
		for (int u = 0; u < n; u++) begin
			res.unknown_index = 3'(u);
			res.solution = x[u];
			res.singular = zero_div_seen;
			res.final_result = (u + 1 == n);
			expected_solutions.push_back(res);
		end
	endtask

	// driver: presents queued load items, records accepted ones for the predictor, drives result_ready
	always @(posedge clk) begin
		if (load_valid && load_ready) quiet_cycles <= 0;
		else if (result_valid && result_ready) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (arst_n && (!load_valid || load_ready)) begin
			if (load_valid) begin
				if (load.kind == KIND_COEF) coef_mem[load.row_index*NMAX+load.column_index] = load.value;
				else rhs_mem[load.row_index] = load.value;
				if (load.last) predict_solution();
			end
			if (pending_loads.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				load <= pending_loads.pop_front();
				load_valid <= 1'b1;
			end else
				load_valid <= 1'b0;
		end
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: compares each result item with the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && result_valid && result_ready) begin
			if (expected_solutions.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result item %p", result);
			end else begin
				exp_res = expected_solutions.pop_front();
				if (result !== exp_res) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("result mismatch: expected %p got %p", exp_res, result);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles > STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_size(logic [3:0] sz);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4*REG_SYS_SIZE); pwdata <= 32'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		size_reg = sz;
	endtask

	task automatic wait_idle();
		while (pending_loads.size() > 0 || load_valid || expected_solutions.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic load_t make_load(logic kind, int row, int col,
			logic signed [31:0] v, logic lst);
		load_t it;
		it.kind = kind; it.row_index = 3'(row); it.column_index = 3'(col);
		it.value = v; it.last = lst;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh80000000;
			2: return 32'sh7fffffff;
			3: return 0;
			default: return $signed($urandom_range(16'hffff, 0) << $urandom_range(4)) * 4
				- 32'sh00020000;
		endcase
	endfunction

	// full system of given size: coefficients, right-hand side, last on final item
	task automatic queue_system(int n, bit zero_diag);
		logic signed [31:0] v;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				v = zero_diag ? 0 : rand_value();
				pending_loads.push_back(make_load(KIND_COEF, r, c, v, 1'b0));
			end
			pending_loads.push_back(make_load(KIND_RHS, r, $urandom_range(7),
				rand_value(), r == n - 1));
		end
	endtask

	initial begin
		int sizes [6] = '{1, 8, 2, 3, 5, 0};
		int idles [4] = '{0, 78, 0, 7};
		int stalls [4] = '{0, 0, 78, 7};
		int sent;
		for (int q = 0; q < NMAX*NMAX; q++) coef_mem[q] = 0;
		for (int q = 0; q < NMAX; q++) rhs_mem[q] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset size, singular, extremes, size one and eight
		queue_system(4, 1'b1);
		wait_idle();
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				pending_loads.push_back(make_load(KIND_COEF, r, c,
					r == c ? 32'sh80000000 : 32'sh7fffffff, 1'b0));
		for (int r = 0; r < 4; r++)
			pending_loads.push_back(make_load(KIND_RHS, r, 7, 32'sh7fffffff, r == 3));
		wait_idle();
		write_size(4'd15);
		queue_system(8, 1'b0);
		wait_idle();
		write_size(4'd1);
		queue_system(1, 1'b0);
		wait_idle();

		// random phases with varying size, idling and stalls
		sent = 0;
		for (int ph = 0; sent < 300; ph++) begin
			send_idle_pct = idles[ph % 4];
			recv_stall_pct = stalls[ph % 4];
			write_size(4'(sizes[ph % 6]));
			for (int s = 0; s < 3; s++) begin
				queue_system(size_reg == 0 ? 1 : (size_reg > 8 ? 8 : size_reg), $urandom_range(9) == 0);
				// overwrite a single entry and resolve
				pending_loads.push_back(make_load($urandom_range(1), 0, 0, rand_value(), 1'b1));
				sent += (size_reg + 1) * (size_reg + 1);
			end
			wait_idle();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		if (mismatches == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/lss_pkg.sv
rtl/lss_ram.sv
rtl/lss_div.sv
rtl/linear_system_solver_top.sv
tb/linear_system_solver_top_tb.sv
